### hw/rtl/frame_bitmap_allocator_unit_assert.svh
// Assertion macros for the frame bitmap allocator.
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("frame allocator check failed");
`define FBA_ASSERT_ON(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("frame allocator check failed");
`else
`define FBA_ASSERT(lbl, clk, rst, prop)
`define FBA_ASSERT_ON(lbl, clk, prop)
`endif
`endif

### hw/rtl/fba_pkg.sv
`timescale 1ns / 1ps
package fba_pkg;

   localparam int FRAME_COUNT_DEFAULT = 8;
   localparam int PAGE_SLOTS_DEFAULT  = 10;

   localparam int OPERATION_W    = 1;
   localparam int PAGE_COUNT_W   = 4;
   localparam int STATUS_W       = 2;
   localparam int PAGE_INDEX_W   = 4;
   localparam int FRAME_NUMBER_W = 3;
   localparam int CMP_W          = 7;

   localparam logic [OPERATION_W-1:0] OP_FREE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd2;

   typedef struct packed {
      logic                latch;
      logic                alloc_start;
      logic                skip;
      logic                take;
      logic                free_start;
      logic                rd;
      logic                clear;
      logic                end_free;
      logic                report;
      logic [STATUS_W-1:0] report_status;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic too_big;
      logic count_zero;
      logic holds;
      logic held_zero;
      logic bit_free;
      logic page_last;
      logic free_last;
      logic out_free;
   } dp_sts_type;

endpackage

### hw/rtl/fba_req_if.sv
`timescale 1ns / 1ps
interface fba_req_if;
   import fba_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OPERATION_W-1:0]  operation;
   logic [PAGE_COUNT_W-1:0] page_count;

   modport source (output valid, output operation, output page_count, input ready);
   modport sink (input valid, input operation, input page_count, output ready);
endinterface

### hw/rtl/fba_rsp_if.sv
`timescale 1ns / 1ps
interface fba_rsp_if;
   import fba_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic                      frame_valid;
   logic [PAGE_INDEX_W-1:0]   page_index;
   logic [FRAME_NUMBER_W-1:0] frame_number;
   logic                      last;

   modport source (output valid, output status, output frame_valid, output page_index,
                   output frame_number, output last, input ready);
   modport sink (input valid, input status, input frame_valid, input page_index,
                 input frame_number, input last, output ready);
endinterface

### hw/rtl/fba_ram.sv
`timescale 1ns / 1ps
module fba_ram #(
   parameter int  WIDTH  = 1,
   parameter int  DEPTH  = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/fba_ctrl.sv
`timescale 1ns / 1ps
module fba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fba_pkg::dp_sts_type sts,
   output fba_pkg::dp_cmd_type cmd
);
   import fba_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_FREE_RD = 3'd3;
   localparam logic [2:0] S_FREE_WR = 3'd4;
   localparam logic [2:0] S_REPORT  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
   end

   always_comb begin
      state_in          = state_ff;
      code_in           = code_ff;
      cmd               = '0;
      cmd.report_status = code_ff;
      req_ready         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_free) begin
               if (!sts.holds) begin
                  code_in  = ST_NOT_HELD;
                  state_in = S_REPORT;
               end else if (sts.held_zero) begin
                  cmd.end_free = 1'b1;
                  code_in      = ST_OK;
                  state_in     = S_REPORT;
               end else begin
                  cmd.free_start = 1'b1;
                  state_in       = S_FREE_RD;
               end
            end else if (sts.too_big) begin
               code_in  = ST_NO_ROOM;
               state_in = S_REPORT;
            end else begin
               cmd.alloc_start = 1'b1;
               if (sts.count_zero) begin
                  code_in  = ST_OK;
                  state_in = S_REPORT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (!sts.bit_free) begin
               cmd.skip = 1'b1;
            end else if (sts.out_free) begin
               cmd.take = 1'b1;
               if (sts.page_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FREE_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.clear = 1'b1;
            if (sts.free_last) begin
               cmd.end_free = 1'b1;
               code_in      = ST_OK;
               state_in     = S_REPORT;
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_REPORT: begin
            if (sts.out_free) begin
               cmd.report = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/fba_dp.sv
`timescale 1ns / 1ps
`include "frame_bitmap_allocator_unit_assert.svh"
module fba_dp #(
   parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEFAULT,
   parameter int PAGE_SLOTS  = fba_pkg::PAGE_SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [fba_pkg::OPERATION_W-1:0]     req_operation,
   input  logic [fba_pkg::PAGE_COUNT_W-1:0]    req_page_count,
   input  fba_pkg::dp_cmd_type                 cmd,
   output fba_pkg::dp_sts_type                 sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [fba_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_frame_valid,
   output logic [fba_pkg::PAGE_INDEX_W-1:0]    rsp_page_index,
   output logic [fba_pkg::FRAME_NUMBER_W-1:0]  rsp_frame_number,
   output logic                                rsp_last
);
   import fba_pkg::*;

   localparam int FW  = $clog2(FRAME_COUNT);
   localparam int FCW = $clog2(FRAME_COUNT + 1);
   localparam int AW  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;

   logic [OPERATION_W-1:0]    op_ff;
   logic [PAGE_COUNT_W-1:0]   count_ff;
   logic [PAGE_COUNT_W-1:0]   held_ff, held_in;
   logic                      holds_ff, holds_in;
   logic [FW-1:0]             ptr_ff, ptr_in;
   logic [PAGE_INDEX_W-1:0]   page_ff, page_in;
   logic [PAGE_COUNT_W-1:0]   idx_ff, idx_in;
   logic [FRAME_COUNT-1:0]    in_use_ff, in_use_in;
   logic [FCW-1:0]            free_cnt_ff, free_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic                      rsp_fvalid_ff;
   logic [PAGE_INDEX_W-1:0]   rsp_page_ff;
   logic [FRAME_NUMBER_W-1:0] rsp_frame_ff;
   logic                      rsp_last_ff;

   logic [FW-1:0] rd_frame;
   logic          rd_ok;
   logic          clear_hit;
   logic          push;

   fba_ram #(
      .WIDTH (FW),
      .DEPTH (PAGE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.take),
      .wr_addr (AW'(page_ff)),
      .wr_data (ptr_ff),
      .rd_en   (cmd.rd),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_frame)
   );

   assign rd_ok     = {1'b0, rd_frame} < (FW + 1)'(FRAME_COUNT);
   assign clear_hit = cmd.clear && rd_ok && in_use_ff[rd_frame];
   assign push      = cmd.take || cmd.report;

   always_comb begin
      sts.is_free    = (op_ff == OP_FREE);
      sts.too_big    = (CMP_W'(count_ff) > CMP_W'(free_cnt_ff))
                       || (CMP_W'(count_ff) > CMP_W'(PAGE_SLOTS));
      sts.count_zero = (count_ff == '0);
      sts.holds      = holds_ff;
      sts.held_zero  = (held_ff == '0);
      sts.bit_free   = !in_use_ff[ptr_ff];
      sts.page_last  = (({1'b0, page_ff} + 5'd1) == {1'b0, count_ff});
      sts.free_last  = (({1'b0, idx_ff} + 5'd1) == {1'b0, held_ff});
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      held_in     = held_ff;
      holds_in    = holds_ff;
      ptr_in      = ptr_ff;
      page_in     = page_ff;
      idx_in      = idx_ff;
      in_use_in   = in_use_ff;
      free_cnt_in = free_cnt_ff;
      if (cmd.alloc_start) begin
         held_in  = count_ff;
         holds_in = 1'b1;
         ptr_in   = '0;
         page_in  = '0;
      end
      if (cmd.skip) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (cmd.take) begin
         in_use_in[ptr_ff] = 1'b1;
         free_cnt_in       = free_cnt_ff - 1'b1;
         ptr_in            = ptr_ff + 1'b1;
         page_in           = page_ff + 1'b1;
      end
      if (cmd.free_start) begin
         idx_in = '0;
      end
      if (cmd.clear) begin
         idx_in = idx_ff + 1'b1;
      end
      if (clear_hit) begin
         in_use_in[rd_frame] = 1'b0;
         free_cnt_in         = free_cnt_ff + 1'b1;
      end
      if (cmd.end_free) begin
         holds_in = 1'b0;
      end
      rsp_valid_in = push || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         holds_ff     <= 1'b0;
         in_use_ff    <= '0;
         free_cnt_ff  <= FCW'(FRAME_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         holds_ff     <= holds_in;
         in_use_ff    <= in_use_in;
         free_cnt_ff  <= free_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff  <= ptr_in;
      page_ff <= page_in;
      idx_ff  <= idx_in;
      if (cmd.latch) begin
         op_ff    <= req_operation;
         count_ff <= req_page_count;
      end
      if (cmd.take) begin
         rsp_status_ff <= ST_OK;
         rsp_fvalid_ff <= 1'b1;
         rsp_page_ff   <= page_ff;
         rsp_frame_ff  <= FRAME_NUMBER_W'(ptr_ff);
         rsp_last_ff   <= sts.page_last;
      end else if (cmd.report) begin
         rsp_status_ff <= cmd.report_status;
         rsp_fvalid_ff <= 1'b0;
         rsp_page_ff   <= '0;
         rsp_frame_ff  <= '0;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_valid  = rsp_fvalid_ff;
   assign rsp_page_index   = rsp_page_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_last         = rsp_last_ff;

   `FBA_ASSERT(a_free_count, clock, reset, free_cnt_ff == FCW'(FRAME_COUNT - $countones(in_use_ff)))
   `FBA_ASSERT(a_take_free_frame, clock, reset, cmd.take |-> !in_use_ff[ptr_ff])
   `FBA_ASSERT(a_no_overwrite, clock, reset, push |-> (!rsp_valid_ff || rsp_ready))
   `FBA_ASSERT_ON(a_reset_quiet, clock, $past(reset) |-> !rsp_valid_ff)

endmodule

### hw/rtl/frame_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// channel  | role   | beat
// req_bus  | sink   | operation, page_count
// rsp_bus  | source | status, frame_valid, page_index, frame_number, last
//
// Allocate: latch, check, then scan from frame 0 up to the last frame taken, skipping
//   used frames and taking free ones, at most FRAME_COUNT frames.
// Free: latch, check, per held page a registered slot RAM read and a clear, then report.
// Reject, zero-page allocate and free of an empty table: latch, check, then report.
// Reset clears the bitmap and flags; no sweep.
// A full result register holds the controller until rsp_bus takes the beat.
module frame_bitmap_allocator_unit #(
   parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEFAULT,
   parameter int PAGE_SLOTS  = fba_pkg::PAGE_SLOTS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   fba_req_if.sink   req_bus,
   fba_rsp_if.source rsp_bus
);
   import fba_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fba_dp #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_SLOTS  (PAGE_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_bus.operation),
      .req_page_count   (req_bus.page_count),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_status       (rsp_bus.status),
      .rsp_frame_valid  (rsp_bus.frame_valid),
      .rsp_page_index   (rsp_bus.page_index),
      .rsp_frame_number (rsp_bus.frame_number),
      .rsp_last         (rsp_bus.last)
   );

endmodule

### tb/frame_grant_checker.sv
`timescale 1ns / 1ps
module frame_grant_checker #(
   parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEFAULT,
   parameter int PAGE_SLOTS  = fba_pkg::PAGE_SLOTS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   fba_req_if   req_bus,
   fba_rsp_if   rsp_bus,
   output int   mismatch_count,
   output int   pending_grants
);
   import fba_pkg::*;

   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      frame_valid;
      logic [PAGE_INDEX_W-1:0]   page_index;
      logic [FRAME_NUMBER_W-1:0] frame_number;
      logic                      last;
   } grant_beat_t;

   logic [FRAME_COUNT-1:0]    frame_used;
   logic [FRAME_NUMBER_W-1:0] slot_frame [PAGE_SLOTS];
   int unsigned               held_pages;
   logic                      holding;
   grant_beat_t               expected_grants [$];

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t ns grant mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic push_grant(input logic [STATUS_W-1:0] status, input logic frame_valid,
                             input int page, input int frame, input logic last);
      grant_beat_t beat;
      beat.status       = status;
      beat.frame_valid  = frame_valid;
      beat.page_index   = PAGE_INDEX_W'(page);
      beat.frame_number = FRAME_NUMBER_W'(frame);
      beat.last         = last;
      expected_grants.push_back(beat);
   endtask

   task automatic predict_grants(input logic [OPERATION_W-1:0] op,
                                 input logic [PAGE_COUNT_W-1:0] pages);
      int free_frames;
      int frame;
      free_frames = 0;
      for (int f = 0; f < FRAME_COUNT; f++) begin
         if (!frame_used[f]) free_frames++;
      end
      if (op == OP_FREE) begin
         if (!holding) begin
            push_grant(ST_NOT_HELD, 1'b0, 0, 0, 1'b1);
         end else begin
            for (int i = 0; i < held_pages && i < PAGE_SLOTS; i++) begin
               frame_used[slot_frame[i]] = 1'b0;
            end
            holding = 1'b0;
            push_grant(ST_OK, 1'b0, 0, 0, 1'b1);
         end
      end else if (int'(pages) > free_frames || int'(pages) > PAGE_SLOTS) begin
         push_grant(ST_NO_ROOM, 1'b0, 0, 0, 1'b1);
      end else begin
         held_pages = pages;
         holding    = 1'b1;
         if (pages == 0) push_grant(ST_OK, 1'b0, 0, 0, 1'b1);
         for (int i = 0; i < int'(pages); i++) begin
            frame = 0;
            while (frame < FRAME_COUNT - 1 && frame_used[frame]) frame++;
            frame_used[frame] = 1'b1;
            slot_frame[i]     = FRAME_NUMBER_W'(frame);
            push_grant(ST_OK, 1'b1, i, frame, i == int'(pages) - 1);
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [3:0] got,
                                input logic [3:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   task automatic check_grant();
      grant_beat_t want;
      if (expected_grants.size() == 0) begin
         report_mismatch($sformatf("unexpected beat status %0h frame_valid %0h",
                                   rsp_bus.status, rsp_bus.frame_valid));
      end else begin
         want = expected_grants.pop_front();
         compare_field("status", rsp_bus.status, want.status);
         compare_field("frame_valid", rsp_bus.frame_valid, want.frame_valid);
         compare_field("page_index", rsp_bus.page_index, want.page_index);
         compare_field("frame_number", rsp_bus.frame_number, want.frame_number);
         compare_field("last", rsp_bus.last, want.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_used     = '0;
         held_pages     = 0;
         holding        = 1'b0;
         mismatch_count = 0;
         expected_grants.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_grants(req_bus.operation, req_bus.page_count);
         end
         if (rsp_bus.valid && rsp_bus.ready) check_grant();
      end
      pending_grants <= expected_grants.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import fba_pkg::*;

   localparam logic [OPERATION_W-1:0] OP_ALLOC = ~OP_FREE;

   localparam int MAX_IDLE     = 18;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AFTER   = 40;
   localparam int PAIR_ITEMS   = 157;
   localparam int NOISE_ITEMS  = 40;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_grants;
   int   accepted_requests;
   bit   req_fast;
   bit   rsp_fast;
   bit   long_hold_done;

   fba_req_if req_bus();
   fba_rsp_if rsp_bus();

   frame_bitmap_allocator_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   frame_grant_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_grants (pending_grants)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_request(input logic [OPERATION_W-1:0] op,
                               input logic [PAGE_COUNT_W-1:0] pages);
      int gap;
      if ($urandom_range(0, 29) == 0) req_fast = !req_fast;
      gap = req_fast ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.page_count <= pages;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      accepted_requests++;
   endtask

   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_fast = !rsp_fast;
         hold = rsp_fast ? 0 : $urandom_range(0, MAX_IDLE);
         if (!long_hold_done && accepted_requests >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold           = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   initial begin
      int issued;
      int kind;
      req_bus.valid      = 1'b0;
      req_bus.operation  = OP_ALLOC;
      req_bus.page_count = '0;
      accepted_requests  = 0;
      reset              = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_FREE, 4'd0);
      send_request(OP_ALLOC, 4'd0);
      send_request(OP_FREE, 4'd15);
      send_request(OP_FREE, 4'd7);
      send_request(OP_ALLOC, 4'd8);
      send_request(OP_ALLOC, 4'd1);
      send_request(OP_FREE, 4'd0);
      send_request(OP_ALLOC, 4'd15);
      send_request(OP_ALLOC, 4'd9);
      send_request(OP_ALLOC, 4'd10);
      send_request(OP_ALLOC, 4'd11);
      send_request(OP_ALLOC, 4'd3);
      send_request(OP_FREE, 4'd0);
      send_request(OP_ALLOC, 4'd5);
      send_request(OP_ALLOC, 4'd4);
      send_request(OP_FREE, 4'd0);
      send_request(OP_ALLOC, 4'd7);
      send_request(OP_FREE, 4'd0);
      // leak frame 0 by allocating over a live table
      send_request(OP_ALLOC, 4'd1);
      send_request(OP_ALLOC, 4'd2);
      send_request(OP_FREE, 4'd0);
      send_request(OP_ALLOC, 4'd7);
      send_request(OP_FREE, 4'd0);

      issued = 0;
      while (issued < PAIR_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_request(OP_FREE, 4'($urandom_range(0, 15)));
            issued += 1;
         end else begin
            if (kind == 1) send_request(OP_ALLOC, 4'($urandom_range(0, 15)));
            else send_request(OP_ALLOC, 4'($urandom_range(1, 7)));
            send_request(OP_FREE, 4'($urandom_range(0, 15)));
            issued += 2;
         end
      end

      repeat (NOISE_ITEMS) begin
         send_request(OPERATION_W'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_grants != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### frame_bitmap_allocator_unit.f
+incdir+hw/rtl
hw/rtl/fba_pkg.sv
hw/rtl/fba_req_if.sv
hw/rtl/fba_rsp_if.sv
hw/rtl/fba_ram.sv
hw/rtl/fba_ctrl.sv
hw/rtl/fba_dp.sv
hw/rtl/frame_bitmap_allocator_unit.sv
tb/frame_grant_checker.sv
tb/tb_top.sv
